// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLKED(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ASSERT_CLKED(lbl, clk, rst_n, !(expr))

`else

`define ASSERT_CLKED(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hdl/lfc_pkg.sv =====
package lfc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 13;
	localparam int QUOT_W   = 16;
	localparam int ACC_W    = SAMPLE_W + CFG_W + 1;
	localparam int CNT_W    = $clog2(QUOT_W);

	localparam logic [CFG_W-1:0] CFG_LEN_RESET = 13'd256;

	typedef struct packed {
		logic capture;
		logic load_step;
		logic rd_en;
		logic rd_p1;
		logic cap_s0;
		logic mul;
		logic sum;
		logic div_step;
		logic play_end;
		logic fade_end;
		logic zero_end;
		logic push;
	} lfc_cmd_t;

	typedef struct packed {
		logic op_load;
		logic play;
		logic fade;
		logic out_free;
	} lfc_sts_t;

endpackage

// ===== hdl/lfc_ram.sv =====
module lfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/lfc_ctrl.sv =====
module lfc_ctrl import lfc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lfc_sts_t sts,
	output lfc_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_READ_NEW,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_FADE_END,
		ST_PLAY_END,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					if (sts.op_load) state_q <= ST_FINISH;
					else if (sts.fade) state_q <= ST_READ_NEW;
					else if (sts.play) state_q <= ST_PLAY_END;
					else state_q <= ST_FINISH;
				end
				ST_READ_NEW: state_q <= ST_MUL;
				ST_MUL:      state_q <= ST_SUM;
				ST_SUM: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(QUOT_W - 1)) state_q <= ST_FADE_END;
					else cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_FADE_END: state_q <= ST_FINISH;
				ST_PLAY_END: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DISPATCH: begin
				if (sts.op_load) cmd.load_step = 1'b1;
				else if (sts.fade || sts.play) cmd.rd_en = 1'b1;
				else cmd.zero_end = 1'b1;
			end
			ST_READ_NEW: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_p1  = 1'b1;
				cmd.cap_s0 = 1'b1;
			end
			ST_MUL:      cmd.mul = 1'b1;
			ST_SUM:      cmd.sum = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_FADE_END: cmd.fade_end = 1'b1;
			ST_PLAY_END: cmd.play_end = 1'b1;
			ST_FINISH:   cmd.push = sts.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

// ===== hdl/lfc_dp.sv =====
module lfc_dp import lfc_pkg::*; #(
	parameter int FRAME_DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_op,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic                in_last,
	input  lfc_cmd_t            cmd,
	output lfc_sts_t            sts,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [SAMPLE_W-1:0] out_sample,
	output logic                out_released,
	output logic                out_rejected
);

	localparam int OFF_W  = $clog2(FRAME_DEPTH);
	localparam int LEN_W  = $clog2(FRAME_DEPTH + 1);
	localparam int ADDR_W = $clog2(2 * FRAME_DEPTH);
	localparam int CMP_W  = ((OFF_W > CFG_W) ? OFF_W : CFG_W) + 1;
	localparam logic [LEN_W-1:0]  DEPTH_L = LEN_W'(FRAME_DEPTH);
	localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(FRAME_DEPTH);

	typedef enum logic [1:0] {
		LT_IDLE  = 2'd0,
		LT_SLOT0 = 2'd1,
		LT_SLOT1 = 2'd2,
		LT_DROP  = 2'd3
	} load_target_t;

	function automatic logic [OFF_W-1:0] advance(input logic [OFF_W-1:0] off,
	                                             input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] nx;
		nx = LEN_W'(off) + LEN_W'(1);
		return (nx >= len) ? '0 : OFF_W'(nx);
	endfunction

	// control state
	logic [CFG_W-1:0] cfg_len_q;
	logic [LEN_W-1:0] len_q [2];
	logic [OFF_W-1:0] off_q [2];
	logic [1:0]       full_q;
	logic             swap_q;
	logic [LEN_W-1:0] ptr_q;
	load_target_t     tgt_q;
	logic             out_valid_q;

	// payload
	logic                       op_q, last_q;
	logic [SAMPLE_W-1:0]        smp_q;
	logic signed [SAMPLE_W-1:0] s0_q;
	logic signed [ACC_W-1:0]    prod0_q, prod1_q;
	logic [CFG_W-1:0]           rem_q;
	logic [QUOT_W-1:0]          dq_q;
	logic                       neg_q;
	logic [SAMPLE_W-1:0]        res_q;
	logic                       rel_q, rej_q;
	logic [SAMPLE_W-1:0]        out_sample_q;
	logic                       out_rel_q, out_rej_q;

	logic                p0, p1;
	logic [SAMPLE_W-1:0] rd_data;

	assign p0 = swap_q;
	assign p1 = ~swap_q;

	assign sts.op_load  = op_q;
	assign sts.fade     = full_q[p0] & full_q[p1];
	assign sts.play     = full_q[p0] & ~full_q[p1];
	assign sts.out_free = ~out_valid_q | out_ready;

	// fade weights and divisor
	logic [CFG_W-1:0]  len_eff, div_d, kw, w0;
	logic [OFF_W-1:0]  k;
	logic [CMP_W-1:0]  k_x;
	logic              fade_over;

	assign len_eff   = (cfg_len_q < CFG_W'(2)) ? CFG_W'(2) : cfg_len_q;
	assign div_d     = len_eff - CFG_W'(1);
	assign k         = off_q[p1];
	assign k_x       = CMP_W'(k);
	assign kw        = (k_x > CMP_W'(div_d)) ? div_d : CFG_W'(k);
	assign w0        = div_d - kw;
	assign fade_over = (k_x + CMP_W'(1)) >= CMP_W'(len_eff);

	logic signed [ACC_W-1:0] acc_sum;
	logic [ACC_W-1:0]        mag;
	logic [CFG_W:0]          div_t;
	logic                    div_ge;

	assign acc_sum = prod0_q + prod1_q;
	assign mag     = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);
	assign div_t   = {rem_q, dq_q[QUOT_W-1]};
	assign div_ge  = div_t >= {1'b0, div_d};

	// load path
	logic [LEN_W-1:0] ptr_eff, ptr_next;
	load_target_t     tgt_eff;
	logic             ld_keep, ld_slot, ptr_room;

	always_comb begin
		ptr_eff = ptr_q;
		tgt_eff = tgt_q;
		if (tgt_q == LT_IDLE) begin
			ptr_eff = '0;
			if (!full_q[p0]) tgt_eff = p0 ? LT_SLOT1 : LT_SLOT0;
			else if (!full_q[p1]) tgt_eff = p1 ? LT_SLOT1 : LT_SLOT0;
			else tgt_eff = LT_DROP;
		end
	end

	assign ld_keep  = (tgt_eff == LT_SLOT0) || (tgt_eff == LT_SLOT1);
	assign ld_slot  = (tgt_eff == LT_SLOT1);
	assign ptr_room = ptr_eff < DEPTH_L;
	assign ptr_next = ptr_room ? ptr_eff + LEN_W'(1) : ptr_eff;

	// frame store
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic              rd_slot;
	logic [OFF_W-1:0]  rd_off;

	assign ram_we    = cmd.load_step & ld_keep & ptr_room;
	assign ram_waddr = ld_slot ? DEPTH_A + ADDR_W'(ptr_eff) : ADDR_W'(ptr_eff);
	assign rd_slot   = cmd.rd_p1 ? p1 : p0;
	assign rd_off    = off_q[rd_slot];
	assign ram_raddr = rd_slot ? DEPTH_A + ADDR_W'(rd_off) : ADDR_W'(rd_off);

	lfc_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(2 * FRAME_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(smp_q),
		.re   (cmd.rd_en),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q   <= CFG_LEN_RESET;
			len_q[0]    <= '0;
			len_q[1]    <= '0;
			off_q[0]    <= '0;
			off_q[1]    <= '0;
			full_q      <= '0;
			swap_q      <= 1'b0;
			ptr_q       <= '0;
			tgt_q       <= LT_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cfg_len_q <= cfg_data;
			if (cmd.load_step) begin
				if (ld_keep && last_q) begin
					len_q[ld_slot]  <= ptr_next;
					off_q[ld_slot]  <= '0;
					full_q[ld_slot] <= 1'b1;
					tgt_q           <= LT_IDLE;
					ptr_q           <= '0;
				end else if (ld_keep) begin
					tgt_q <= tgt_eff;
					ptr_q <= ptr_next;
				end else if (last_q) begin
					tgt_q <= LT_IDLE;
					ptr_q <= '0;
				end else begin
					tgt_q <= LT_DROP;
					ptr_q <= ptr_eff;
				end
			end
			if (cmd.play_end) off_q[p0] <= advance(off_q[p0], len_q[p0]);
			if (cmd.fade_end) begin
				off_q[p1] <= advance(off_q[p1], len_q[p1]);
				if (fade_over) begin
					full_q[p0] <= 1'b0;
					off_q[p0]  <= '0;
					swap_q     <= p1;
				end else begin
					off_q[p0] <= advance(off_q[p0], len_q[p0]);
				end
			end
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			smp_q  <= in_sample;
			last_q <= in_last;
		end
		if (cmd.cap_s0) s0_q <= $signed(rd_data);
		if (cmd.mul) begin
			prod0_q <= s0_q * $signed({1'b0, w0});
			prod1_q <= $signed(rd_data) * $signed({1'b0, kw});
		end
		if (cmd.sum) begin
			neg_q <= acc_sum[ACC_W-1];
			rem_q <= mag[CFG_W+QUOT_W-1:QUOT_W];
			dq_q  <= mag[QUOT_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? CFG_W'(div_t - {1'b0, div_d}) : CFG_W'(div_t);
			dq_q  <= {dq_q[QUOT_W-2:0], div_ge};
		end
		if (cmd.load_step) begin
			res_q <= '0;
			rel_q <= 1'b0;
			rej_q <= ~ld_keep & last_q;
		end
		if (cmd.zero_end) begin
			res_q <= '0;
			rel_q <= 1'b0;
			rej_q <= 1'b0;
		end
		if (cmd.play_end) begin
			res_q <= rd_data;
			rel_q <= 1'b0;
			rej_q <= 1'b0;
		end
		if (cmd.fade_end) begin
			res_q <= neg_q ? SAMPLE_W'(-dq_q) : SAMPLE_W'(dq_q);
			rel_q <= fade_over;
			rej_q <= 1'b0;
		end
		if (cmd.push) begin
			out_sample_q <= res_q;
			out_rel_q    <= rel_q;
			out_rej_q    <= rej_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_sample   = out_sample_q;
	assign out_released = out_rel_q;
	assign out_rejected = out_rej_q;

endmodule

// ===== hdl/looping_frame_crossfader_top.sv =====
// One input item is taken at a time: s_axis_tready is low from the input transfer until the
// result is pushed into the output register, which waits while a previous result is not yet taken.
// A crossfade tick takes the longest, as its weighted sum runs through the
// 16-step restoring divider that normalizes the weighted sum (one frame-store read port).
// Reset (arst_n low, asynchronous): both slots empty, no load in progress,
// crossfade length 256, no result pending. Frame store contents are not cleared.
`include "assert_macros.svh"

module looping_frame_crossfader_top import lfc_pkg::*; #(
	parameter int FRAME_DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [15:0]         s_axis_tdata,   // [15:0] sample_value
	input  logic                s_axis_tlast,
	input  logic [0:0]          s_axis_tuser,   // [0] opcode
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [15:0]         m_axis_tdata,   // [15:0] out_sample
	output logic [1:0]          m_axis_tuser,   // [0] frame_released, [1] frame_rejected
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data
);

	lfc_cmd_t cmd;
	lfc_sts_t sts;

	assign cfg_ready = 1'b1;

	lfc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lfc_dp #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.in_op       (s_axis_tuser[0]),
		.in_sample   (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_sample  (m_axis_tdata),
		.out_released(m_axis_tuser[0]),
		.out_rejected(m_axis_tuser[1])
	);

	`ASSERT_CLKED(a_one_item_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
	`ASSERT_CLKED(a_push_into_free_slot, clk, arst_n, cmd.push |-> (!m_axis_tvalid || m_axis_tready))
	`ASSERT_NEVER(a_release_and_reject, clk, arst_n, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])

endmodule
